@@ hw/rtl/cmpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cmpt_pkg
// shared types, widths and helpers for the colour matrix pixel transform
// ----------------------------------------------------------------------------
package cmpt_pkg;

  localparam int NUM_CH    = 4;
  localparam int CH_W      = 8;
  localparam int COEF_W    = 16;
  localparam int REG_W     = NUM_CH * COEF_W;
  localparam int PROD_W    = 24;
  localparam int PSUM_W    = 26;
  localparam int SUM_W     = 27;
  localparam int FRAC_BITS = 11;
  localparam int OFS_SHIFT = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = NUM_CH * CH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_WTS   = 3'd0,
    REG_GREEN_WTS = 3'd1,
    REG_BLUE_WTS  = 3'd2,
    REG_ALPHA_WTS = 3'd3,
    REG_OFFSETS   = 3'd4
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RED_WTS_RST   = 64'h0800_0000_0000_0000;
  localparam logic [REG_W-1:0] GREEN_WTS_RST = 64'h0000_0800_0000_0000;
  localparam logic [REG_W-1:0] BLUE_WTS_RST  = 64'h0000_0000_0800_0000;
  localparam logic [REG_W-1:0] ALPHA_WTS_RST = 64'h0000_0000_0000_0800;
  localparam logic [REG_W-1:0] OFFSETS_RST   = 64'h0;

  typedef logic [CH_W-1:0]          chan_t;
  typedef chan_t [NUM_CH-1:0]       pix_t;
  typedef logic [REG_W-1:0]         wreg_t;
  typedef wreg_t [NUM_CH-1:0]       wmat_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [NUM_CH-1:0]       prod_row_t;
  typedef prod_row_t [NUM_CH-1:0]   prod_mat_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef psum_t [NUM_CH-1:0]       psum_row_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // output x field: red in the top 16 bits, alpha in the bottom
  function automatic coef_t coef_field(input wreg_t r, input int x);
    coef_field = coef_t'(r[(NUM_CH - 1 - x) * COEF_W +: COEF_W]);
  endfunction

endpackage

@@ hw/rtl/cmpt_mult.sv @@
// ----------------------------------------------------------------------------
// cmpt_mult
// first stage: sixteen channel by weight products, registered
// ----------------------------------------------------------------------------
module cmpt_mult (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  cmpt_pkg::pix_t      pix,
  input  logic                last,
  input  cmpt_pkg::wmat_t     wts,
  output cmpt_pkg::stage_ctl_t ctl,
  input  logic                dn_ready,
  output cmpt_pkg::prod_mat_t prod
);
  import cmpt_pkg::*;

  prod_mat_t prod_next;

  assign up_ready = !ctl.valid || dn_ready;

  // prod[x][y]: input channel y into output channel x
  always_comb begin
    for (int x = 0; x < NUM_CH; x++) begin
      for (int y = 0; y < NUM_CH; y++) begin
        prod_next[x][y] = PROD_W'($signed({1'b0, pix[y]}) * coef_field(wts[y], x));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (up_ready) begin
      ctl.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctl.last <= last;
      prod     <= prod_next;
    end
  end

endmodule

@@ hw/rtl/cmpt_sum.sv @@
// ----------------------------------------------------------------------------
// cmpt_sum
// second stage: pairwise product sums, offset folded into the second pair
// ----------------------------------------------------------------------------
module cmpt_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  cmpt_pkg::stage_ctl_t up_ctl,
  output logic                 up_ready,
  input  cmpt_pkg::prod_mat_t  prod,
  input  cmpt_pkg::wreg_t      offsets,
  output cmpt_pkg::stage_ctl_t ctl,
  input  logic                 dn_ready,
  output cmpt_pkg::psum_row_t  sum_a,
  output cmpt_pkg::psum_row_t  sum_b
);
  import cmpt_pkg::*;

  psum_row_t sum_a_next;
  psum_row_t sum_b_next;
  psum_t     ofs;

  assign up_ready = !ctl.valid || dn_ready;

  always_comb begin
    ofs = '0;
    for (int x = 0; x < NUM_CH; x++) begin
      ofs = PSUM_W'(coef_field(offsets, x)) <<< OFS_SHIFT;
      sum_a_next[x] = PSUM_W'($signed(prod[x][0])) + PSUM_W'($signed(prod[x][1]));
      sum_b_next[x] = PSUM_W'($signed(prod[x][2])) + PSUM_W'($signed(prod[x][3])) + ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (up_ready) begin
      ctl.valid <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      ctl.last <= up_ctl.last;
      sum_a    <= sum_a_next;
      sum_b    <= sum_b_next;
    end
  end

endmodule

@@ hw/rtl/cmpt_sat.sv @@
// ----------------------------------------------------------------------------
// cmpt_sat
// third stage: final add, floor to integer and saturate to 0..255
// ----------------------------------------------------------------------------
module cmpt_sat (
  input  logic                 clk,
  input  logic                 rst,
  input  cmpt_pkg::stage_ctl_t up_ctl,
  output logic                 up_ready,
  input  cmpt_pkg::psum_row_t  sum_a,
  input  cmpt_pkg::psum_row_t  sum_b,
  output cmpt_pkg::stage_ctl_t ctl,
  input  logic                 dn_ready,
  output cmpt_pkg::pix_t       pix
);
  import cmpt_pkg::*;

  logic signed [SUM_W-1:0] total [NUM_CH];
  pix_t                    pix_next;

  assign up_ready = !ctl.valid || dn_ready;

  always_comb begin
    for (int x = 0; x < NUM_CH; x++) begin
      total[x] = SUM_W'(sum_a[x]) + SUM_W'(sum_b[x]);
      if (total[x][SUM_W-1]) begin
        pix_next[x] = '0;
      end else if (|total[x][SUM_W-2:FRAC_BITS+CH_W]) begin
        pix_next[x] = '1;
      end else begin
        pix_next[x] = total[x][FRAC_BITS +: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (up_ready) begin
      ctl.valid <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      ctl.last <= up_ctl.last;
      pix      <= pix_next;
    end
  end

endmodule

@@ hw/rtl/color_matrix_pixel_transform_unit.sv @@
// three-stage multiply, add, saturate pipeline; every stage registers its pixel
// throughput: one pixel per cycle while m_axis_tready is high, set by that pipeline
// each stage holds its pixel under back-pressure and refills as soon as it drains
// reset: synchronous active-high rst empties the pipeline and loads the identity matrix
// ----------------------------------------------------------------------------
// color_matrix_pixel_transform_unit
// rgba 5x4 colour matrix: weighted channel sums plus offset, floored and saturated
// ----------------------------------------------------------------------------
module color_matrix_pixel_transform_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [cmpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmpt_pkg::REG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cmpt_pkg::PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cmpt_pkg::PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                            m_axis_tlast
);
  import cmpt_pkg::*;

  wmat_t      wts;
  wreg_t      offsets;
  pix_t       in_pix;
  pix_t       out_pix;
  prod_mat_t  prod;
  psum_row_t  sum_a;
  psum_row_t  sum_b;
  stage_ctl_t mult_ctl;
  stage_ctl_t sum_ctl;
  stage_ctl_t sat_ctl;
  logic       sum_ready;
  logic       sat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wts[REG_RED_WTS]   <= RED_WTS_RST;
      wts[REG_GREEN_WTS] <= GREEN_WTS_RST;
      wts[REG_BLUE_WTS]  <= BLUE_WTS_RST;
      wts[REG_ALPHA_WTS] <= ALPHA_WTS_RST;
      offsets            <= OFFSETS_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RED_WTS:   wts[REG_RED_WTS]   <= cfg_data;
        REG_GREEN_WTS: wts[REG_GREEN_WTS] <= cfg_data;
        REG_BLUE_WTS:  wts[REG_BLUE_WTS]  <= cfg_data;
        REG_ALPHA_WTS: wts[REG_ALPHA_WTS] <= cfg_data;
        REG_OFFSETS:   offsets            <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int y = 0; y < NUM_CH; y++) begin
      in_pix[y] = s_axis_tdata[y * CH_W +: CH_W];
      m_axis_tdata[y * CH_W +: CH_W] = out_pix[y];
    end
  end

  cmpt_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_axis_tvalid),
    .up_ready (s_axis_tready),
    .pix      (in_pix),
    .last     (s_axis_tlast),
    .wts      (wts),
    .ctl      (mult_ctl),
    .dn_ready (sum_ready),
    .prod     (prod)
  );

  cmpt_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_ctl   (mult_ctl),
    .up_ready (sum_ready),
    .prod     (prod),
    .offsets  (offsets),
    .ctl      (sum_ctl),
    .dn_ready (sat_ready),
    .sum_a    (sum_a),
    .sum_b    (sum_b)
  );

  cmpt_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .up_ctl   (sum_ctl),
    .up_ready (sat_ready),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .ctl      (sat_ctl),
    .dn_ready (m_axis_tready),
    .pix      (out_pix)
  );

  assign m_axis_tvalid = sat_ctl.valid;
  assign m_axis_tlast  = sat_ctl.last;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// colour matrix pixel transform testbench
// streams rgba pixels through the unit under random source gaps and sink
// stalls, predicts every output pixel from a shadow copy of the five matrix
// registers, and reloads the matrix between runs once the pipeline drains
// ----------------------------------------------------------------------------
module testbench;
  import cmpt_pkg::*;

  localparam int NUM_REGS    = int'(REG_OFFSETS) + 1;
  localparam int LATENCY     = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int CH_MAX      = 255;
  localparam int PHASES      = 20;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  last;
  } rgba_t;

  typedef enum int {NEAR_IDENTITY, BROAD, ANY_BITS} setting_kind_t;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_wen = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata = '0;  // in_red, in_green, in_blue, in_alpha
  logic                 s_axis_tlast = 0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [PIX_W-1:0]     m_axis_tdata;       // out_red, out_green, out_blue, out_alpha
  logic                 m_axis_tlast;

  rgba_t pixel_queue[$];
  rgba_t expected_pixels[$];
  rgba_t sending_pixel;
  rgba_t monitor_want;
  wreg_t colour_regs [NUM_REGS];
  bit    failed = 0;
  int    send_gap = 0;
  int    send_calm = 0;
  int    stall_left = 0;
  int    stall_calm = 0;
  int    quiet_cycles = 0;

  color_matrix_pixel_transform_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // exact weighted sum, floored and clamped to a pixel
  function automatic rgba_t transform_pixel(rgba_t p);
    rgba_t              q;
    chan_t              ch [NUM_CH];
    chan_t              res [NUM_CH];
    logic signed [39:0] acc;
    ch[0] = p.red;
    ch[1] = p.green;
    ch[2] = p.blue;
    ch[3] = p.alpha;
    for (int x = 0; x < NUM_CH; x++) begin
      acc = $signed(colour_regs[REG_OFFSETS][(NUM_CH-1-x)*COEF_W +: COEF_W]);
      acc = acc <<< OFS_SHIFT;
      for (int y = 0; y < NUM_CH; y++)
        acc += $signed({1'b0, ch[y]}) * $signed(colour_regs[y][(NUM_CH-1-x)*COEF_W +: COEF_W]);
      if (acc < 0) res[x] = '0;
      else if ((acc >>> FRAC_BITS) > CH_MAX) res[x] = CH_W'(CH_MAX);
      else res[x] = acc[FRAC_BITS +: CH_W];
    end
    q.red   = res[0];
    q.green = res[1];
    q.blue  = res[2];
    q.alpha = res[3];
    q.last  = p.last;
    return q;
  endfunction

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic chan_t pick_channel();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return CH_W'(CH_MAX);
    return CH_W'($urandom_range(0, CH_MAX));
  endfunction

  function automatic rgba_t random_pixel();
    rgba_t p;
    p.red   = pick_channel();
    p.green = pick_channel();
    p.blue  = pick_channel();
    p.alpha = pick_channel();
    p.last  = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // row selects the diagonal weight; the offset row has none
  function automatic wreg_t random_row(setting_kind_t kind, int row);
    wreg_t r;
    coef_t c;
    for (int x = 0; x < NUM_CH; x++) begin
      case (kind)
        NEAR_IDENTITY: c = COEF_W'((x == row ? 2048 : 0) + $urandom_range(0, 1023) - 512);
        BROAD:         c = COEF_W'($urandom_range(0, 8191) - 4096);
        default:       c = COEF_W'($urandom);
      endcase
      r[(NUM_CH-1-x)*COEF_W +: COEF_W] = c;
    end
    return r;
  endfunction

  task automatic add_pixel(chan_t r, chan_t g, chan_t b, chan_t a, logic last);
    pixel_queue.push_back('{r, g, b, a, last});
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, wreg_t value);
    @(posedge clk);
    cfg_wen   <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx < NUM_REGS) colour_regs[idx] = value;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  task automatic load_matrix(wreg_t rw, wreg_t gw, wreg_t bw, wreg_t aw, wreg_t ofs);
    write_register(REG_RED_WTS, rw);
    write_register(REG_GREEN_WTS, gw);
    write_register(REG_BLUE_WTS, bw);
    write_register(REG_ALPHA_WTS, aw);
    write_register(REG_OFFSETS, ofs);
  endtask

  // sampled between edges so the driver and monitor have settled
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      failed = 1;
    end
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(transform_pixel(sending_pixel));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || pixel_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 0;
        end else begin
          sending_pixel = pixel_queue.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tdata  <= {sending_pixel.alpha, sending_pixel.blue,
                            sending_pixel.green, sending_pixel.red};
          s_axis_tlast  <= sending_pixel.last;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = pick_pause();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 150);
          end
        end
      end
    end
  end

  // sink side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      if (stall_calm > 0) begin
        stall_calm--;
      end else begin
        stall_left = pick_pause();
        if ($urandom_range(0, 39) == 0) stall_calm = $urandom_range(20, 150);
      end
    end
  end

  // output transaction check
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output transaction, expected none actual data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        failed = 1;
      end else begin
        monitor_want = expected_pixels.pop_front();
        check_field("red", monitor_want.red, m_axis_tdata[0*CH_W +: CH_W]);
        check_field("green", monitor_want.green, m_axis_tdata[1*CH_W +: CH_W]);
        check_field("blue", monitor_want.blue, m_axis_tdata[2*CH_W +: CH_W]);
        check_field("alpha", monitor_want.alpha, m_axis_tdata[3*CH_W +: CH_W]);
        check_field("last", monitor_want.last, m_axis_tlast);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_wen || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    setting_kind_t kind;
    colour_regs[REG_RED_WTS]   = RED_WTS_RST;
    colour_regs[REG_GREEN_WTS] = GREEN_WTS_RST;
    colour_regs[REG_BLUE_WTS]  = BLUE_WTS_RST;
    colour_regs[REG_ALPHA_WTS] = ALPHA_WTS_RST;
    colour_regs[REG_OFFSETS]   = OFFSETS_RST;
    repeat (4) @(posedge clk);
    rst <= 0;

    // identity after reset
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1);
    add_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 0);
    add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1);
    add_pixel(8'h01, 8'h02, 8'h03, 8'h04, 0);
    add_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1);
    wait_idle();

    // writes beyond the register file must leave the matrix alone
    for (int idx = NUM_REGS; idx < (1 << CFG_IDX_W); idx++)
      write_register(CFG_IDX_W'(idx), {$urandom, $urandom});
    add_pixel(8'd12, 8'd34, 8'd56, 8'd78, 0);
    add_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1);
    wait_idle();

    // largest positive weights and offsets saturate high
    load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_pixel(8'h01, 8'h00, 8'h00, 8'h00, 1);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    wait_idle();

    // most negative weights and offsets clamp to zero
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    add_pixel(8'h07, 8'h80, 8'h01, 8'hFE, 1);
    wait_idle();

    // offsets alone: exactly one, flooring just below one, tiny negative, exactly 256
    load_matrix('0, '0, '0, '0, {16'h0040, 16'h003F, 16'hFFFF, 16'h4000});
    add_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 0);
    wait_idle();
    write_register(REG_OFFSETS, {16'h3FFF, 16'hFFC0, 16'h0000, 16'h7FFF});
    add_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1);
    wait_idle();

    // negative weight cancelling a positive one to exactly zero, then one above
    load_matrix({16'h0800, 16'h0800, 16'h0000, 16'h0000},
                {16'hF800, 16'h0000, 16'h0800, 16'h0000},
                {16'h0000, 16'hF800, 16'hF800, 16'h0000},
                {16'h0000, 16'h0000, 16'h0000, 16'h0001},
                {16'h0000, 16'h0000, 16'h0040, 16'h0000});
    add_pixel(8'd100, 8'd100, 8'd100, 8'hFF, 0);
    add_pixel(8'd101, 8'd100, 8'd99, 8'h08, 1);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       kind = BROAD;
        1:       kind = ANY_BITS;
        default: kind = NEAR_IDENTITY;
      endcase
      if (phase == PHASES - 1)
        load_matrix(RED_WTS_RST, GREEN_WTS_RST, BLUE_WTS_RST, ALPHA_WTS_RST, OFFSETS_RST);
      else
        load_matrix(random_row(kind, 0), random_row(kind, 1), random_row(kind, 2),
                    random_row(kind, 3), random_row(kind, NUM_CH));
      for (int n = 0; n < PHASE_ITEMS; n++)
        pixel_queue.push_back(random_pixel());
      wait_idle();
    end

    if (failed)
      $display("simulation failed");
    else
      $display("simulation ok");
    $finish;
  end

endmodule
